>>> design/dba_pkg.sv
// Shared types and constants for the decimating boxcar averager.
// Used by dba_div, dba_ctrl, dba_datapath and decimating_boxcar_averager.
// No dependencies.
package dba_pkg;

  localparam int SCAN_CHANNELS = 8;
  localparam int MAX_VARIABLES = 8;

  localparam int CHAN_W  = 16;
  localparam int SUM_W   = 32;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 16;
  localparam int NV_W    = 4;
  localparam int SEL_W   = 3;
  localparam int MAP_W   = SEL_W * MAX_VARIABLES;
  localparam int ID_W    = 15;
  localparam int LEN_W   = 5;
  localparam int DATA_W  = 24;
  localparam int INDEX_W = 3;

  // One quotient bit per step over the full dividend
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  // Time rollover correction, in tenths of milliseconds and in milliseconds
  localparam logic signed [TIME_W-1:0] TENTH_MS_SEC      = 32'sd10000;
  localparam logic signed [TIME_W-1:0] TENTH_MS_HALF_SEC = 32'sd5000;
  localparam logic signed [TIME_W-1:0] MS_SEC            = 32'sd1000;
  localparam logic signed [TIME_W-1:0] MS_HALF_SEC       = 32'sd500;

  // Register reset values
  localparam logic [CNT_W-1:0] DECIMATION_RST = 16'd1;
  localparam logic [CNT_W-1:0] POINTS_RST     = 16'd1;
  localparam logic [NV_W-1:0]  VARS_RST       = 4'd8;
  localparam logic [MAP_W-1:0] MAP_RST        = 24'hFAC688;
  localparam logic [ID_W-1:0]  ID_RST         = 15'd0;

  typedef enum logic [INDEX_W-1:0] {
    REG_DECIMATION,
    REG_POINTS,
    REG_VARS,
    REG_MAP,
    REG_ID
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef logic [SCAN_CHANNELS-1:0][CHAN_W-1:0] chan_vec_t;
  typedef logic [MAX_VARIABLES-1:0][CHAN_W-1:0] avg_vec_t;

  typedef struct packed {
    logic [CNT_W-1:0] decimation;
    logic [CNT_W-1:0] points;
    logic [NV_W-1:0]  vars;
    logic [MAP_W-1:0] sel_map;
    logic [ID_W-1:0]  id;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic emit;
  } status_t;

endpackage

>>> design/dba_div.sv
// Iterative restoring divider for one averaging lane, one quotient bit per step.
// Signed dividend, unsigned divisor, quotient saturated to 16 bits.
// Depends on dba_pkg.
module dba_div (
  input  logic                              clk,
  input  logic                              load,
  input  logic                              step,
  input  logic signed [dba_pkg::SUM_W-1:0]  dividend,
  input  logic [dba_pkg::CNT_W-1:0]         divisor,
  output logic signed [dba_pkg::CHAN_W-1:0] quotient
);
  import dba_pkg::*;

  logic              neg;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem <= '0;
    end else if (step) begin
      rem <= fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  // Saturate the magnitude, then restore the sign
  always_comb begin
    if (neg) begin
      if (quo > SUM_W'(32768)) begin
        quotient = 16'sh8000;
      end else begin
        quotient = CHAN_W'(-quo[CHAN_W-1:0]);
      end
    end else begin
      if (quo > SUM_W'(32767)) begin
        quotient = 16'sh7FFF;
      end else begin
        quotient = quo[CHAN_W-1:0];
      end
    end
  end

endmodule

>>> design/dba_ctrl.sv
// Controller for the decimating boxcar averager: handshakes, sequencing and
// division step count. Depends on dba_pkg.
module dba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  dba_pkg::status_t status,
  output dba_pkg::cmd_t    cmd
);
  import dba_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept && status.emit) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (step_cnt == STEP_LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (cmd.capture) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd.accept  = in_valid && in_ready;
    cmd.load    = (state == ST_LOAD);
    cmd.step    = (state == ST_DIV);
    cmd.capture = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load) begin
      step_cnt <= '0;
    end else if (cmd.step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_emit_starts_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.emit) |=> (state == ST_LOAD))
    else $error("closing scan did not start a division");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.capture)
    else $error("result overwritten before it was taken");

  a_full_division: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step_cnt == STEP_LAST) |=> (state == ST_DONE))
    else $error("division did not end after its last step");

  a_capture_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (out_valid && state == ST_IDLE))
    else $error("capture did not present a result");

endmodule

>>> design/dba_datapath.sv
// Datapath for the decimating boxcar averager: scan counter, per-variable sums,
// time midpoint, lane dividers and output registers. Depends on dba_pkg, dba_div.
module dba_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  dba_pkg::cmd_t                     cmd,
  output dba_pkg::status_t                  status,
  input  dba_pkg::cfg_t                     cfg,
  input  logic signed [dba_pkg::TIME_W-1:0] scan_time,
  input  dba_pkg::chan_vec_t                chan,
  output logic signed [dba_pkg::TIME_W-1:0] mid_time,
  output logic [dba_pkg::ID_W-1:0]          out_id,
  output logic [dba_pkg::LEN_W-1:0]         payload_bytes,
  output dba_pkg::avg_vec_t                 avg
);
  import dba_pkg::*;

  logic [CNT_W-1:0]         scan_count;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     in_window;
  logic                     first_scan;
  logic [NV_W-1:0]          nv;
  logic [MAX_VARIABLES-1:0] lane_on;

  logic [MAX_VARIABLES-1:0][SUM_W-1:0]  sums;
  logic [MAX_VARIABLES-1:0][SUM_W-1:0]  sum_add;
  logic [MAX_VARIABLES-1:0][CHAN_W-1:0] quo;

  logic signed [TIME_W-1:0] first_time;
  logic signed [TIME_W-1:0] diff;
  logic signed [TIME_W-1:0] diff_fix;
  logic signed [TIME_W-1:0] dcorr;
  logic [TIME_W-1:0]        round_in;
  logic [TIME_W-1:0]        half;

  assign cnt_inc     = scan_count + 1'b1;
  assign in_window   = (cnt_inc <= cfg.points);
  assign first_scan  = (cnt_inc == CNT_W'(1));
  assign status.emit = (cnt_inc == cfg.points);

  assign nv = (cfg.vars > NV_W'(MAX_VARIABLES)) ? NV_W'(MAX_VARIABLES) : cfg.vars;

  always_comb begin
    for (int i = 0; i < MAX_VARIABLES; i++) begin
      logic [SEL_W-1:0]  sel;
      logic [CHAN_W-1:0] pick;
      sel        = cfg.sel_map[SEL_W*i +: SEL_W];
      pick       = chan[sel];
      lane_on[i] = (NV_W'(i) < nv);
      sum_add[i] = sums[i] + {{(SUM_W-CHAN_W){pick[CHAN_W-1]}}, pick};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_count <= '0;
      sums       <= '0;
      first_time <= '0;
    end else begin
      if (cmd.accept) begin
        scan_count <= (cnt_inc == cfg.decimation) ? '0 : cnt_inc;
        if (in_window) begin
          for (int i = 0; i < MAX_VARIABLES; i++) begin
            if (lane_on[i]) sums[i] <= sum_add[i];
          end
          if (first_scan) first_time <= scan_time;
        end
      end
      if (cmd.load) sums <= '0;
    end
  end

  // Rollover correction on the span between first and last scan
  always_comb begin
    if (diff < -TENTH_MS_HALF_SEC) begin
      diff_fix = diff + TENTH_MS_SEC;
    end else if (diff < -MS_HALF_SEC) begin
      diff_fix = diff + MS_SEC;
    end else begin
      diff_fix = diff;
    end
  end

  // Halve toward zero: bias negatives by one, then shift
  assign round_in = dcorr + {{(TIME_W-1){1'b0}}, dcorr[TIME_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      diff <= first_scan ? '0 : scan_time - first_time;
    end
    if (cmd.load) begin
      dcorr <= diff_fix;
    end
    if (cmd.step) begin
      half <= {round_in[TIME_W-1], round_in[TIME_W-1:1]};
    end
  end

  for (genvar g = 0; g < MAX_VARIABLES; g++) begin : g_lane
    dba_div u_div (
      .clk      (clk),
      .load     (cmd.load),
      .step     (cmd.step),
      .dividend (sums[g]),
      .divisor  (cfg.points),
      .quotient (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mid_time      <= first_time + half;
      out_id        <= cfg.id;
      payload_bytes <= LEN_W'({NV_W'(nv + NV_W'(1)), 1'b0});
      for (int i = 0; i < MAX_VARIABLES; i++) begin
        avg[i] <= (lane_on[i] && (cfg.points != '0)) ? quo[i] : '0;
      end
    end
  end

endmodule

>>> design/decimating_boxcar_averager.sv
// Decimating boxcar averager, top level: configuration registers and port mapping.
// A scan that closes an average gives its result word after a load, the 32 steps of
// the restoring divider in each lane and a capture that waits while an older result
// is untaken; the controller then takes the next scan. Other scans bring no stall.
// Reset (synchronous) clears counter, sums and first time and restores the registers.
// Depends on dba_pkg, dba_ctrl, dba_datapath, dba_div.
module decimating_boxcar_averager (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cfg_we,
  input  logic [dba_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [dba_pkg::DATA_W-1:0]          cfg_data,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dba_pkg::TIME_W-1:0]   scan_time,
  input  logic signed [dba_pkg::CHAN_W-1:0]   chan_0,
  input  logic signed [dba_pkg::CHAN_W-1:0]   chan_1,
  input  logic signed [dba_pkg::CHAN_W-1:0]   chan_2,
  input  logic signed [dba_pkg::CHAN_W-1:0]   chan_3,
  input  logic signed [dba_pkg::CHAN_W-1:0]   chan_4,
  input  logic signed [dba_pkg::CHAN_W-1:0]   chan_5,
  input  logic signed [dba_pkg::CHAN_W-1:0]   chan_6,
  input  logic signed [dba_pkg::CHAN_W-1:0]   chan_7,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dba_pkg::TIME_W-1:0]   mid_time,
  output logic [dba_pkg::ID_W-1:0]            out_id,
  output logic [dba_pkg::LEN_W-1:0]           payload_bytes,
  output logic signed [dba_pkg::CHAN_W-1:0]   avg_0,
  output logic signed [dba_pkg::CHAN_W-1:0]   avg_1,
  output logic signed [dba_pkg::CHAN_W-1:0]   avg_2,
  output logic signed [dba_pkg::CHAN_W-1:0]   avg_3,
  output logic signed [dba_pkg::CHAN_W-1:0]   avg_4,
  output logic signed [dba_pkg::CHAN_W-1:0]   avg_5,
  output logic signed [dba_pkg::CHAN_W-1:0]   avg_6,
  output logic signed [dba_pkg::CHAN_W-1:0]   avg_7
);
  import dba_pkg::*;

  cfg_t      cfg;
  cmd_t      cmd;
  status_t   status;
  chan_vec_t chan;
  avg_vec_t  avg;

  // Configuration registers. Writes must come only while the block is idle; the
  // block itself does not enforce this and has no guard against a write in the
  // middle of an average. Unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decimation <= DECIMATION_RST;
      cfg.points     <= POINTS_RST;
      cfg.vars       <= VARS_RST;
      cfg.sel_map    <= MAP_RST;
      cfg.id         <= ID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DECIMATION: cfg.decimation <= cfg_data[CNT_W-1:0];
        REG_POINTS:     cfg.points     <= cfg_data[CNT_W-1:0];
        REG_VARS:       cfg.vars       <= cfg_data[NV_W-1:0];
        REG_MAP:        cfg.sel_map    <= cfg_data[MAP_W-1:0];
        REG_ID:         cfg.id         <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the scan channels into one vector for the selection muxes
  assign chan = {chan_7, chan_6, chan_5, chan_4, chan_3, chan_2, chan_1, chan_0};

  // Controller: accepts a scan word whenever it is idle, even while a finished
  // result word still waits at the output, and steps the lane dividers.
  dba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: counter, sums, midpoint time, eight lane dividers, output register
  dba_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .scan_time     (scan_time),
    .chan          (chan),
    .mid_time      (mid_time),
    .out_id        (out_id),
    .payload_bytes (payload_bytes),
    .avg           (avg)
  );

  assign avg_0 = avg[0];
  assign avg_1 = avg[1];
  assign avg_2 = avg[2];
  assign avg_3 = avg[3];
  assign avg_4 = avg[4];
  assign avg_5 = avg[5];
  assign avg_6 = avg[6];
  assign avg_7 = avg[7];

endmodule
